### design/pcq_pkg.sv
`default_nettype none
package pcq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int MAX_WORKERS = 8;
   localparam int TABLE_DEPTH = 24;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int QCNT_W      = 5;
   localparam int RCNT_W      = 4;

   typedef logic [2:0] mode_type;
   localparam mode_type MODE_SUBMIT   = 3'd0;
   localparam mode_type MODE_CANCEL   = 3'd1;
   localparam mode_type MODE_TAKE     = 3'd2;
   localparam mode_type MODE_FINISH   = 3'd3;
   localparam mode_type MODE_SHUTDOWN = 3'd4;

   typedef logic [2:0] status_type;
   localparam status_type ST_QUEUED    = 3'd0;
   localparam status_type ST_RUNNING   = 3'd1;
   localparam status_type ST_COMPLETED = 3'd2;
   localparam status_type ST_CANCELLED = 3'd3;
   localparam status_type ST_TIMEOUT   = 3'd4;
   localparam status_type ST_FAILED    = 3'd5;
   localparam status_type ST_REJECTED  = 3'd6;
   localparam status_type ST_IDLE_RES  = 3'd7;

   typedef logic [2:0] reason_type;
   localparam reason_type RS_NONE      = 3'd0;
   localparam reason_type RS_ZERO_ID   = 3'd1;
   localparam reason_type RS_SHUT_DOWN = 3'd2;
   localparam reason_type RS_DUPLICATE = 3'd3;
   localparam reason_type RS_FULL      = 3'd4;
   localparam reason_type RS_NOT_HELD  = 3'd5;
   localparam reason_type RS_RUNNING   = 3'd6;
   localparam reason_type RS_NOTHING   = 3'd7;

   localparam logic [1:0] OUT_COMPLETED = 2'd0;
   localparam logic [1:0] OUT_TIMEOUT   = 2'd2;

   typedef struct packed {
      logic [31:0] age;
      logic [1:0]  prio;
      logic [31:0] cmd;
      logic [31:0] exec_id;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [2:0] {
      FSM_IDLE = 3'b001,
      FSM_SCAN = 3'b010,
      FSM_EXEC = 3'b100
   } fsm_type;

endpackage
`default_nettype wire

### design/pcq_ram.sv
`default_nettype none
module pcq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

### design/priority_command_queue.sv
`default_nettype none
// Channel | Dir | Ports                          | Contents
// req     | in  | req_tvalid/tready/tdata/tuser  | one command word, mode in tuser
// rsp     | out | rsp_tvalid/tready/tdata/tlast  | one result word, tlast ends a command
// csr     | in  | csr_valid/ready/index/data     | register write, index 0 or 1
//
// An ordinary command is accepted in IDLE, then reads all 24 table entries in turn
// through the single read port of the entry RAM, whose read data is registered,
// and finally updates the table and drives the result. Shutdown rescans the
// table once per queued entry, plus a last pass. Reset is synchronous and
// clears the valid/running bits at once, so no clearing pass is needed.
// A held result stalls the update cycle until rsp_tready frees the output.
module priority_command_queue (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [31:0] cmd id, [33:32] priority_req, [65:34] target exec id,
   // [67:66] outcome, [71:68] zero
   input  wire logic [71:0] req_tdata,
   // [2:0] mode
   input  wire logic [2:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [31:0] exec id, [63:32] cmd id of that exec, [65:64] result_priority,
   // [68:66] status, [71:69] reason, [76:72] queued_count,
   // [80:77] running_count, [85:81] high_watermark, [89:86] peak_running,
   // [95:90] zero
   output logic [95:0]      rsp_tdata,
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [4:0]  csr_data
);
   localparam int IW = pcq_pkg::IDX_W;
   localparam int CW = pcq_pkg::CNT_W;
   localparam int QW = pcq_pkg::QCNT_W;
   localparam int RW = pcq_pkg::RCNT_W;
   localparam int TD = pcq_pkg::TABLE_DEPTH;

   // control state
   pcq_pkg::fsm_type          state_ff, state_in;
   logic [TD-1:0]             valid_ff, valid_in;
   logic [TD-1:0]             running_ff, running_in;
   logic [31:0]               next_exec_ff, next_exec_in;
   logic [31:0]               next_age_ff, next_age_in;
   logic                      accepting_ff, accepting_in;
   logic [QW-1:0]             queued_ff, queued_in;
   logic [RW-1:0]             running_cnt_ff, running_cnt_in;
   logic [QW-1:0]             queued_peak_ff, queued_peak_in;
   logic [RW-1:0]             running_peak_ff, running_peak_in;
   logic [4:0]                max_queue_ff;
   logic [3:0]                worker_limit_ff;
   logic [CW-1:0]             scan_idx_ff, scan_idx_in;
   logic                      rd_vld_ff, rd_vld_in;
   logic                      found_ff, found_in;
   logic                      dup_ff, dup_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // payload
   pcq_pkg::mode_type         op_mode_ff, op_mode_in;
   logic [31:0]               op_cmd_ff, op_cmd_in;
   logic [1:0]                op_prio_ff, op_prio_in;
   logic [31:0]               op_target_ff, op_target_in;
   logic [1:0]                op_outcome_ff, op_outcome_in;
   logic [IW-1:0]             cmp_idx_ff, cmp_idx_in;
   logic [IW-1:0]             best_idx_ff, best_idx_in;
   pcq_pkg::entry_type        best_ff, best_in;
   logic                      best_run_ff, best_run_in;
   logic [95:0]               rsp_data_ff, rsp_data_in;
   logic                      rsp_last_ff, rsp_last_in;

   // entry RAM
   logic                      ram_we;
   logic [IW-1:0]             ram_waddr;
   pcq_pkg::entry_type        ram_wdata;
   pcq_pkg::entry_type        ram_rdata;

   pcq_ram #(
      .WIDTH (pcq_pkg::ENTRY_W),
      .DEPTH (TD)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (scan_idx_ff[IW-1:0]),
      .rd_data (ram_rdata)
   );

   // scan compare on the entry just read
   logic        cur_v, cur_r, cand, dup_hit, take_hit, older;
   logic [31:0] dist_cur, dist_best;

   always_comb begin
      cur_v     = valid_ff[cmp_idx_ff];
      cur_r     = running_ff[cmp_idx_ff];
      cand      = cur_v && !cur_r;
      dist_cur  = next_age_ff - ram_rdata.age;
      dist_best = next_age_ff - best_ff.age;
      older     = dist_cur > dist_best;
      dup_hit   = 1'b0;
      take_hit  = 1'b0;
      case (op_mode_ff)
         pcq_pkg::MODE_SUBMIT: begin
            dup_hit = cur_v && (ram_rdata.cmd == op_cmd_ff);
         end
         pcq_pkg::MODE_CANCEL, pcq_pkg::MODE_FINISH: begin
            take_hit = cur_v && !found_ff && (op_target_ff != 32'd0) &&
                       (ram_rdata.exec_id == op_target_ff);
         end
         pcq_pkg::MODE_TAKE: begin
            take_hit = cand && (!found_ff || (ram_rdata.prio > best_ff.prio) ||
                       ((ram_rdata.prio == best_ff.prio) && older));
         end
         pcq_pkg::MODE_SHUTDOWN: begin
            take_hit = cand && (!found_ff || older);
         end
         default: begin
            take_hit = 1'b0;
         end
      endcase
   end

   // first free slot
   logic          slot_found;
   logic [IW-1:0] slot_idx;

   always_comb begin
      slot_found = 1'b0;
      slot_idx   = '0;
      for (int i = TD - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            slot_found = 1'b1;
            slot_idx   = IW'(i);
         end
      end
   end

   // clamped limits
   logic [QW-1:0] qlim;
   logic [RW-1:0] wlim;

   always_comb begin
      qlim = max_queue_ff;
      if (max_queue_ff == 5'd0) begin
         qlim = QW'(1);
      end else if (max_queue_ff > QW'(pcq_pkg::QUEUE_DEPTH)) begin
         qlim = QW'(pcq_pkg::QUEUE_DEPTH);
      end
      wlim = worker_limit_ff;
      if (worker_limit_ff == 4'd0) begin
         wlim = RW'(1);
      end else if (worker_limit_ff > RW'(pcq_pkg::MAX_WORKERS)) begin
         wlim = RW'(pcq_pkg::MAX_WORKERS);
      end
   end

   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // sequencer
   logic [31:0]         o_ex, o_cmd;
   logic [1:0]          o_prio;
   pcq_pkg::status_type o_st;
   pcq_pkg::reason_type o_rs, sub_rs;
   logic [QW-1:0]       o_qc;

   always_comb begin
      state_in        = state_ff;
      valid_in        = valid_ff;
      running_in      = running_ff;
      next_exec_in    = next_exec_ff;
      next_age_in     = next_age_ff;
      accepting_in    = accepting_ff;
      queued_in       = queued_ff;
      running_cnt_in  = running_cnt_ff;
      queued_peak_in  = queued_peak_ff;
      running_peak_in = running_peak_ff;
      scan_idx_in     = scan_idx_ff;
      rd_vld_in       = 1'b0;
      found_in        = found_ff;
      dup_in          = dup_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      op_mode_in      = op_mode_ff;
      op_cmd_in       = op_cmd_ff;
      op_prio_in      = op_prio_ff;
      op_target_in    = op_target_ff;
      op_outcome_in   = op_outcome_ff;
      cmp_idx_in      = scan_idx_ff[IW-1:0];
      best_idx_in     = best_idx_ff;
      best_in         = best_ff;
      best_run_in     = best_run_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_last_in     = rsp_last_ff;
      ram_we          = 1'b0;
      ram_waddr       = slot_idx;
      ram_wdata       = '{age: next_age_ff, prio: op_prio_ff, cmd: op_cmd_ff,
                          exec_id: next_exec_ff};
      o_ex            = 32'd0;
      o_cmd           = 32'd0;
      o_prio          = 2'd0;
      o_st            = pcq_pkg::ST_IDLE_RES;
      o_rs            = pcq_pkg::RS_NONE;
      sub_rs          = pcq_pkg::RS_NONE;
      o_qc            = '0;

      case (state_ff)
         pcq_pkg::FSM_IDLE: begin
            if (req_tvalid) begin
               op_mode_in    = req_tuser;
               op_cmd_in     = req_tdata[31:0];
               op_prio_in    = req_tdata[33:32];
               op_target_in  = req_tdata[65:34];
               op_outcome_in = req_tdata[67:66];
               scan_idx_in   = '0;
               found_in      = 1'b0;
               dup_in        = 1'b0;
               state_in      = pcq_pkg::FSM_SCAN;
            end
         end
         pcq_pkg::FSM_SCAN: begin
            // issue one read a cycle, judge the entry returned in the next cycle
            rd_vld_in = scan_idx_ff < CW'(TD);
            if (rd_vld_in) begin
               scan_idx_in = scan_idx_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               if (dup_hit) begin
                  dup_in = 1'b1;
               end
               if (take_hit) begin
                  found_in    = 1'b1;
                  best_in     = ram_rdata;
                  best_idx_in = cmp_idx_ff;
                  best_run_in = cur_r;
               end
               if (cmp_idx_ff == IW'(TD - 1)) begin
                  state_in = pcq_pkg::FSM_EXEC;
               end
            end
         end
         pcq_pkg::FSM_EXEC: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               state_in     = pcq_pkg::FSM_IDLE;
               case (op_mode_ff)
                  pcq_pkg::MODE_SUBMIT: begin
                     next_exec_in = (next_exec_ff == 32'hFFFF_FFFF) ? 32'd1 :
                                    next_exec_ff + 32'd1;
                     if (op_cmd_ff == 32'd0) begin
                        sub_rs = pcq_pkg::RS_ZERO_ID;
                     end else if (!accepting_ff) begin
                        sub_rs = pcq_pkg::RS_SHUT_DOWN;
                     end else if (dup_ff) begin
                        sub_rs = pcq_pkg::RS_DUPLICATE;
                     end else if ((queued_ff >= qlim) || !slot_found) begin
                        sub_rs = pcq_pkg::RS_FULL;
                     end
                     o_ex   = next_exec_ff;
                     o_cmd  = op_cmd_ff;
                     o_prio = op_prio_ff;
                     if (sub_rs != pcq_pkg::RS_NONE) begin
                        o_st = pcq_pkg::ST_REJECTED;
                        o_rs = sub_rs;
                     end else begin
                        ram_we                = 1'b1;
                        valid_in[slot_idx]    = 1'b1;
                        running_in[slot_idx]  = 1'b0;
                        next_age_in           = next_age_ff + 32'd1;
                        queued_in             = queued_ff + QW'(1);
                        if (queued_in > queued_peak_ff) begin
                           queued_peak_in = queued_in;
                        end
                        o_st = pcq_pkg::ST_QUEUED;
                     end
                  end
                  pcq_pkg::MODE_CANCEL, pcq_pkg::MODE_FINISH: begin
                     if (!found_ff) begin
                        o_ex = op_target_ff;
                        o_st = pcq_pkg::ST_REJECTED;
                        o_rs = pcq_pkg::RS_NOT_HELD;
                     end else begin
                        o_ex   = best_ff.exec_id;
                        o_cmd  = best_ff.cmd;
                        o_prio = best_ff.prio;
                        if (op_mode_ff == pcq_pkg::MODE_CANCEL) begin
                           if (best_run_ff) begin
                              o_st = pcq_pkg::ST_REJECTED;
                              o_rs = pcq_pkg::RS_RUNNING;
                           end else begin
                              o_st                  = pcq_pkg::ST_CANCELLED;
                              valid_in[best_idx_ff] = 1'b0;
                              if (queued_ff != '0) begin
                                 queued_in = queued_ff - QW'(1);
                              end
                           end
                        end else if (!best_run_ff) begin
                           o_st = pcq_pkg::ST_REJECTED;
                           o_rs = pcq_pkg::RS_NOT_HELD;
                        end else begin
                           case (op_outcome_ff)
                              pcq_pkg::OUT_COMPLETED: o_st = pcq_pkg::ST_COMPLETED;
                              pcq_pkg::OUT_TIMEOUT:   o_st = pcq_pkg::ST_TIMEOUT;
                              default:                o_st = pcq_pkg::ST_FAILED;
                           endcase
                           valid_in[best_idx_ff]   = 1'b0;
                           running_in[best_idx_ff] = 1'b0;
                           if (running_cnt_ff != '0) begin
                              running_cnt_in = running_cnt_ff - RW'(1);
                           end
                        end
                     end
                  end
                  pcq_pkg::MODE_TAKE: begin
                     if (found_ff && (running_cnt_ff < wlim)) begin
                        running_in[best_idx_ff] = 1'b1;
                        if (queued_ff != '0) begin
                           queued_in = queued_ff - QW'(1);
                        end
                        running_cnt_in = running_cnt_ff + RW'(1);
                        if (running_cnt_in > running_peak_ff) begin
                           running_peak_in = running_cnt_in;
                        end
                        o_ex   = best_ff.exec_id;
                        o_cmd  = best_ff.cmd;
                        o_prio = best_ff.prio;
                        o_st   = pcq_pkg::ST_RUNNING;
                     end else begin
                        o_rs = pcq_pkg::RS_NOTHING;
                     end
                  end
                  pcq_pkg::MODE_SHUTDOWN: begin
                     accepting_in = 1'b0;
                     if (found_ff) begin
                        // drop the oldest queued entry and rescan for the next
                        o_ex                  = best_ff.exec_id;
                        o_cmd                 = best_ff.cmd;
                        o_prio                = best_ff.prio;
                        o_st                  = pcq_pkg::ST_CANCELLED;
                        valid_in[best_idx_ff] = 1'b0;
                        if (queued_ff != '0) begin
                           queued_in = queued_ff - QW'(1);
                        end
                        rsp_last_in = 1'b0;
                        scan_idx_in = '0;
                        found_in    = 1'b0;
                        state_in    = pcq_pkg::FSM_SCAN;
                     end else begin
                        o_st = pcq_pkg::ST_COMPLETED;
                     end
                  end
                  default: begin
                     o_st = pcq_pkg::ST_IDLE_RES;
                  end
               endcase
               // shutdown reports the count left after the whole command
               o_qc = (op_mode_ff == pcq_pkg::MODE_SHUTDOWN) ? '0 : queued_in;
               rsp_data_in = {6'd0, running_peak_in, queued_peak_in, running_cnt_in,
                              o_qc, o_rs, o_st, o_prio, o_cmd, o_ex};
            end
         end
         default: begin
            state_in = pcq_pkg::FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= pcq_pkg::FSM_IDLE;
         valid_ff        <= '0;
         running_ff      <= '0;
         next_exec_ff    <= 32'd1;
         next_age_ff     <= 32'd0;
         accepting_ff    <= 1'b1;
         queued_ff       <= '0;
         running_cnt_ff  <= '0;
         queued_peak_ff  <= '0;
         running_peak_ff <= '0;
         max_queue_ff    <= 5'd16;
         worker_limit_ff <= 4'd4;
         scan_idx_ff     <= '0;
         rd_vld_ff       <= 1'b0;
         found_ff        <= 1'b0;
         dup_ff          <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         valid_ff        <= valid_in;
         running_ff      <= running_in;
         next_exec_ff    <= next_exec_in;
         next_age_ff     <= next_age_in;
         accepting_ff    <= accepting_in;
         queued_ff       <= queued_in;
         running_cnt_ff  <= running_cnt_in;
         queued_peak_ff  <= queued_peak_in;
         running_peak_ff <= running_peak_in;
         scan_idx_ff     <= scan_idx_in;
         rd_vld_ff       <= rd_vld_in;
         found_ff        <= found_in;
         dup_ff          <= dup_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (csr_valid) begin
            if (csr_index) begin
               worker_limit_ff <= csr_data[3:0];
            end else begin
               max_queue_ff <= csr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      op_mode_ff    <= op_mode_in;
      op_cmd_ff     <= op_cmd_in;
      op_prio_ff    <= op_prio_in;
      op_target_ff  <= op_target_in;
      op_outcome_ff <= op_outcome_in;
      cmp_idx_ff    <= cmp_idx_in;
      best_idx_ff   <= best_idx_in;
      best_ff       <= best_in;
      best_run_ff   <= best_run_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_tready = (state_ff == pcq_pkg::FSM_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign csr_ready  = 1'b1;

`ifndef NO_ASSERTIONS
   a_queued_count: assert property (@(posedge clock) disable iff (reset)
      queued_ff == QW'($countones(valid_ff & ~running_ff)))
      else $error("queued count out of step with table");
   a_running_count: assert property (@(posedge clock) disable iff (reset)
      running_cnt_ff == RW'($countones(running_ff)))
      else $error("running count out of step with table");
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == pcq_pkg::FSM_SCAN))
      else $error("accepted command did not start a scan");
   a_exec_hold: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == pcq_pkg::FSM_EXEC) && rsp_valid_ff && !rsp_tready)
      |=> (state_ff == pcq_pkg::FSM_EXEC))
      else $error("update ran over a held result");
`endif
endmodule
`default_nettype wire
